>>> rtl/obcs_pkg.sv
// Package for the order book cosine similarity block.
// Holds shared constants, opcodes and state types; depends on nothing.
`default_nettype none
package obcs_pkg;

    localparam int MAX_LEVELS_DEF = 4096;

    localparam int CNT_W   = 13;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 24;
    localparam int SUM_W   = 64;
    localparam int RATIO_W = 14;
    localparam int PCT_W   = 15;
    localparam int CFG_IDX_W = 3;

    // Scaled dot product and the wide products of the cosine unit.
    localparam int SCALED_W  = 75;
    localparam int PROD_W    = 152;
    localparam int MUL_STEPS = SCALED_W;
    localparam int STEP_W    = 7;

    localparam logic [CNT_W-1:0]   COUNT_MAX  = 13'd8191;
    localparam logic [PCT_W-1:0]   HALF_SCALE = 15'd12800;
    localparam logic [RATIO_W-1:0] RATIO_MAX  = 14'd12800;
    localparam logic [PCT_W-1:0]   FULL_SCALE = 15'd25600;

    localparam logic [CNT_W-1:0] CP0_RESET = 13'd50;
    localparam logic [CNT_W-1:0] CP1_RESET = 13'd100;
    localparam logic [CNT_W-1:0] CP2_RESET = 13'd1000;
    localparam logic [CNT_W-1:0] CP3_RESET = 13'd4000;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SERVER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CP0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CP1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CP2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CP3 = 3'd3;

    localparam logic [1:0] CP_IDX0 = 2'd0;
    localparam logic [1:0] CP_IDX1 = 2'd1;
    localparam logic [1:0] CP_IDX2 = 2'd2;
    localparam logic [1:0] CP_IDX3 = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_MAC,
        ST_CHECK,
        ST_EVAL,
        ST_COS
    } walk_state_t;

    typedef enum logic [2:0] {
        COS_IDLE,
        COS_MUL_P,
        COS_MUL_Q,
        COS_TRY,
        COS_CMP
    } cos_state_t;

endpackage
`default_nettype wire

>>> rtl/order_book_cosine_similarity.sv
// Top level of the order book cosine similarity block.
// Depends on obcs_pkg and the cosine ratio unit obcs_cos.
//
// The block holds one side of a local order book as price and quantity levels
// in a single synchronous memory and compares a stream of server levels to it
// by a sorted merge. A clear or an append item never raises busy. A server
// item keeps busy high while its walk reads local levels and compares their
// prices with its own; the walk stops on a higher local price, on an equal
// price or at the end of the book. Each memory read is registered and its
// compare follows in the next cycle. A server item that arrives once the
// server count has reached its ceiling is accepted and dropped at once.
// When the server count hits a checkpoint level with both square sums
// nonzero, the cosine unit runs two serial multiplications, then a
// bit-by-bit ratio search, and then hands over the ratio, so such an item
// keeps busy high longer.
// A result is shown for exactly one cycle with result_valid high; the
// receiver cannot stall it. The configuration port is always ready and is
// meant to be written only while the block is idle.
`default_nettype none
module order_book_cosine_similarity #(
    parameter int MAX_LEVELS = obcs_pkg::MAX_LEVELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        opcode,
    input  wire logic [obcs_pkg::PRICE_W-1:0]      level_price,
    input  wire logic [obcs_pkg::QTY_W-1:0]        level_quantity,
    output logic                                   result_valid,
    output logic [1:0]                             checkpoint_index,
    output logic [obcs_pkg::PCT_W-1:0]             similarity_percent,
    output logic                                   zero_length_error,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [obcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [obcs_pkg::CNT_W-1:0]        cfg_data
);
    localparam int AW = $clog2(MAX_LEVELS);
    localparam int CW = $clog2(MAX_LEVELS + 1);
    localparam int EW = obcs_pkg::PRICE_W + obcs_pkg::QTY_W;
    localparam int QW = obcs_pkg::QTY_W;
    localparam int SW = obcs_pkg::SUM_W;

    // Each entry packs the price above the quantity.
    logic [EW-1:0] level_mem [MAX_LEVELS];
    logic [EW-1:0] rd_data_reg;

    obcs_pkg::walk_state_t state_reg, state_next;
    logic [CW-1:0] local_count_reg, local_count_next;
    logic [CW-1:0] walk_ptr_reg, walk_ptr_next;
    logic [obcs_pkg::CNT_W-1:0] server_count_reg, server_count_next;
    logic [SW-1:0] dot_sum_reg, dot_sum_next;
    logic [SW-1:0] ssum_reg, ssum_next;
    logic [SW-1:0] lsum_reg, lsum_next;
    logic [obcs_pkg::CNT_W-1:0] cp_reg [4];

    logic [obcs_pkg::PRICE_W-1:0] price_reg, price_next;
    logic [QW-1:0]   qty_reg, qty_next;
    logic [2*QW-1:0] sq_reg, sq_next;
    logic [2*QW-1:0] dot_prod_reg, dot_prod_next;
    logic [2*QW-1:0] loc_prod_reg, loc_prod_next;
    logic [1:0]      hit_idx_reg, hit_idx_next;

    logic                          res_valid_reg, res_valid_next;
    logic [1:0]                    res_idx_reg, res_idx_next;
    logic [obcs_pkg::PCT_W-1:0]    res_pct_reg, res_pct_next;
    logic                          res_err_reg, res_err_next;

    logic mem_we;
    logic accept;
    logic cos_start;
    logic cos_done;
    logic [obcs_pkg::RATIO_W-1:0] cos_ratio;
    logic [obcs_pkg::PRICE_W-1:0] rd_price;
    logic [QW-1:0]                rd_qty;
    logic hit_any;
    logic [1:0] hit_sel;

    assign accept   = start && (state_reg == obcs_pkg::ST_IDLE);
    assign rd_price = rd_data_reg[EW-1:QW];
    assign rd_qty   = rd_data_reg[QW-1:0];
    assign mem_we   = accept && (opcode == obcs_pkg::OP_APPEND)
                      && (local_count_reg != CW'(MAX_LEVELS));

    // The matching checkpoint with the lowest index wins.
    always_comb
    begin
        hit_any = 1'b1;
        hit_sel = obcs_pkg::CP_IDX0;
        if (server_count_reg == cp_reg[0])
            hit_sel = obcs_pkg::CP_IDX0;
        else if (server_count_reg == cp_reg[1])
            hit_sel = obcs_pkg::CP_IDX1;
        else if (server_count_reg == cp_reg[2])
            hit_sel = obcs_pkg::CP_IDX2;
        else if (server_count_reg == cp_reg[3])
            hit_sel = obcs_pkg::CP_IDX3;
        else
            hit_any = 1'b0;
    end

    always_comb
    begin
        state_next        = state_reg;
        local_count_next  = local_count_reg;
        walk_ptr_next     = walk_ptr_reg;
        server_count_next = server_count_reg;
        dot_sum_next      = dot_sum_reg;
        ssum_next         = ssum_reg;
        lsum_next         = lsum_reg;
        price_next        = price_reg;
        qty_next          = qty_reg;
        sq_next           = sq_reg;
        dot_prod_next     = dot_prod_reg;
        loc_prod_next     = loc_prod_reg;
        hit_idx_next      = hit_idx_reg;
        res_valid_next    = 1'b0;
        res_idx_next      = res_idx_reg;
        res_pct_next      = res_pct_reg;
        res_err_next      = res_err_reg;
        cos_start         = 1'b0;
        case (state_reg)
            obcs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (opcode)
                        obcs_pkg::OP_CLEAR:
                        begin
                            local_count_next  = '0;
                            walk_ptr_next     = '0;
                            server_count_next = '0;
                            dot_sum_next      = '0;
                            ssum_next         = '0;
                            lsum_next         = '0;
                        end
                        obcs_pkg::OP_APPEND:
                        begin
                            if (mem_we)
                                local_count_next = local_count_reg + 1'b1;
                        end
                        obcs_pkg::OP_SERVER:
                        begin
                            if (server_count_reg != obcs_pkg::COUNT_MAX)
                            begin
                                server_count_next = server_count_reg + 1'b1;
                                price_next        = level_price;
                                qty_next          = level_quantity;
                                state_next        = obcs_pkg::ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = obcs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            obcs_pkg::ST_READ:
            begin
                // The memory read of the walk pointer's entry is in flight.
                sq_next = qty_reg * qty_reg;
                if (walk_ptr_reg < local_count_reg)
                    state_next = obcs_pkg::ST_CMP;
                else
                    state_next = obcs_pkg::ST_CHECK;
            end
            obcs_pkg::ST_CMP:
            begin
                if (rd_price == price_reg)
                begin
                    dot_prod_next = rd_qty * qty_reg;
                    loc_prod_next = rd_qty * rd_qty;
                    state_next    = obcs_pkg::ST_MAC;
                end
                else if (rd_price > price_reg)
                    state_next = obcs_pkg::ST_CHECK;
                else
                begin
                    walk_ptr_next = walk_ptr_reg + 1'b1;
                    state_next    = obcs_pkg::ST_READ;
                end
            end
            obcs_pkg::ST_MAC:
            begin
                dot_sum_next = dot_sum_reg + SW'(dot_prod_reg);
                lsum_next    = lsum_reg + SW'(loc_prod_reg);
                state_next   = obcs_pkg::ST_CHECK;
            end
            obcs_pkg::ST_CHECK:
            begin
                ssum_next  = ssum_reg + SW'(sq_reg);
                state_next = obcs_pkg::ST_EVAL;
            end
            obcs_pkg::ST_EVAL:
            begin
                hit_idx_next = hit_sel;
                if (!hit_any)
                    state_next = obcs_pkg::ST_IDLE;
                else if ((ssum_reg == '0) || (lsum_reg == '0))
                begin
                    res_valid_next = 1'b1;
                    res_idx_next   = hit_sel;
                    res_pct_next   = '0;
                    res_err_next   = 1'b1;
                    state_next     = obcs_pkg::ST_IDLE;
                end
                else
                begin
                    cos_start  = 1'b1;
                    state_next = obcs_pkg::ST_COS;
                end
            end
            obcs_pkg::ST_COS:
            begin
                if (cos_done)
                begin
                    res_valid_next = 1'b1;
                    res_idx_next   = hit_idx_reg;
                    res_pct_next   = obcs_pkg::HALF_SCALE + obcs_pkg::PCT_W'(cos_ratio);
                    res_err_next   = 1'b0;
                    state_next     = obcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = obcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= obcs_pkg::ST_IDLE;
            local_count_reg  <= '0;
            walk_ptr_reg     <= '0;
            server_count_reg <= '0;
            dot_sum_reg      <= '0;
            ssum_reg         <= '0;
            lsum_reg         <= '0;
            res_valid_reg    <= 1'b0;
            cp_reg[0]        <= obcs_pkg::CP0_RESET;
            cp_reg[1]        <= obcs_pkg::CP1_RESET;
            cp_reg[2]        <= obcs_pkg::CP2_RESET;
            cp_reg[3]        <= obcs_pkg::CP3_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            local_count_reg  <= local_count_next;
            walk_ptr_reg     <= walk_ptr_next;
            server_count_reg <= server_count_next;
            dot_sum_reg      <= dot_sum_next;
            ssum_reg         <= ssum_next;
            lsum_reg         <= lsum_next;
            res_valid_reg    <= res_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    obcs_pkg::CFG_CP0: cp_reg[0] <= cfg_data;
                    obcs_pkg::CFG_CP1: cp_reg[1] <= cfg_data;
                    obcs_pkg::CFG_CP2: cp_reg[2] <= cfg_data;
                    obcs_pkg::CFG_CP3: cp_reg[3] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        price_reg    <= price_next;
        qty_reg      <= qty_next;
        sq_reg       <= sq_next;
        dot_prod_reg <= dot_prod_next;
        loc_prod_reg <= loc_prod_next;
        hit_idx_reg  <= hit_idx_next;
        res_idx_reg  <= res_idx_next;
        res_pct_reg  <= res_pct_next;
        res_err_reg  <= res_err_next;
    end

    // Level store: one write port for appends, one registered read port for
    // the walk. The walk pointer never exceeds the local count, and a read is
    // used only while the pointer lies below it, so the low bits suffice.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            level_mem[local_count_reg[AW-1:0]] <= {level_price, level_quantity};
        rd_data_reg <= level_mem[walk_ptr_reg[AW-1:0]];
    end

    obcs_cos u_cos (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (cos_start),
        .dot_sum           (dot_sum_reg),
        .server_square_sum (ssum_reg),
        .local_square_sum  (lsum_reg),
        .done              (cos_done),
        .ratio             (cos_ratio)
    );

    assign busy               = (state_reg != obcs_pkg::ST_IDLE);
    assign cfg_ready          = 1'b1;
    assign result_valid       = res_valid_reg;
    assign checkpoint_index   = res_idx_reg;
    assign similarity_percent = res_pct_reg;
    assign zero_length_error  = res_err_reg;

endmodule
`default_nettype wire

>>> rtl/obcs_cos.sv
// Cosine ratio unit: largest r <= 12800 with r^2*S*L <= (12800*dot)^2.
// Serial shift-add products, then a bit-by-bit search; uses obcs_pkg.
`default_nettype none
module obcs_cos (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [obcs_pkg::SUM_W-1:0]    dot_sum,
    input  wire logic [obcs_pkg::SUM_W-1:0]    server_square_sum,
    input  wire logic [obcs_pkg::SUM_W-1:0]    local_square_sum,
    output logic                               done,
    output logic [obcs_pkg::RATIO_W-1:0]       ratio
);
    localparam int W  = obcs_pkg::PROD_W;
    localparam int SW = obcs_pkg::SCALED_W;

    obcs_pkg::cos_state_t state_reg, state_next;
    logic [obcs_pkg::STEP_W-1:0]  cnt_reg, cnt_next;
    logic [3:0]                   k_reg, k_next;
    logic                         done_reg, done_next;
    logic [obcs_pkg::RATIO_W-1:0] r_reg, r_next;
    logic [W-1:0]  acc_reg, acc_next, mc_reg, mc_next;
    logic [SW-1:0] mp_reg, mp_next;
    logic [W-1:0]  p_reg, p_next, q_reg, q_next;
    logic [W-1:0]  a_reg, a_next, b_reg, b_next, t_reg, t_next;

    logic [W-1:0]  acc_step;
    logic [SW-1:0] dot_x25;
    logic [SW-1:0] dot_scaled;
    logic [obcs_pkg::RATIO_W-1:0] cand;

    // 12800 * dot = (16 + 8 + 1) * dot * 512.
    assign dot_x25    = (SW'(dot_sum) << 4) + (SW'(dot_sum) << 3) + SW'(dot_sum);
    assign dot_scaled = dot_x25 << 9;
    assign acc_step   = mp_reg[0] ? (acc_reg + mc_reg) : acc_reg;
    assign cand       = r_reg | (obcs_pkg::RATIO_W'(1) << k_reg);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        r_next     = r_reg;
        acc_next   = acc_reg;
        mc_next    = mc_reg;
        mp_next    = mp_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        t_next     = t_reg;
        case (state_reg)
            obcs_pkg::COS_IDLE:
            begin
                if (start)
                begin
                    acc_next   = '0;
                    mc_next    = W'(server_square_sum);
                    mp_next    = SW'(local_square_sum);
                    cnt_next   = obcs_pkg::STEP_W'(obcs_pkg::MUL_STEPS);
                    state_next = obcs_pkg::COS_MUL_P;
                end
            end
            obcs_pkg::COS_MUL_P:
            begin
                acc_next = acc_step;
                mc_next  = mc_reg << 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == obcs_pkg::STEP_W'(1))
                begin
                    p_next     = acc_step;
                    acc_next   = '0;
                    mc_next    = W'(dot_scaled);
                    mp_next    = dot_scaled;
                    cnt_next   = obcs_pkg::STEP_W'(obcs_pkg::MUL_STEPS);
                    state_next = obcs_pkg::COS_MUL_Q;
                end
            end
            obcs_pkg::COS_MUL_Q:
            begin
                acc_next = acc_step;
                mc_next  = mc_reg << 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == obcs_pkg::STEP_W'(1))
                begin
                    q_next     = acc_step;
                    r_next     = '0;
                    a_next     = '0;
                    b_next     = '0;
                    k_next     = 4'd13;
                    state_next = obcs_pkg::COS_TRY;
                end
            end
            obcs_pkg::COS_TRY:
            begin
                // (r + 2^k)^2 P = r^2 P + 2^(k+1) r P + 2^(2k) P
                t_next = a_reg + (b_reg << (k_reg + 4'd1)) + (p_reg << {k_reg, 1'b0});
                state_next = obcs_pkg::COS_CMP;
            end
            obcs_pkg::COS_CMP:
            begin
                if ((t_reg <= q_reg) && (cand <= obcs_pkg::RATIO_MAX))
                begin
                    r_next = cand;
                    a_next = t_reg;
                    b_next = b_reg + (p_reg << k_reg);
                end
                if (k_reg == 4'd0)
                begin
                    done_next  = 1'b1;
                    state_next = obcs_pkg::COS_IDLE;
                end
                else
                begin
                    k_next     = k_reg - 4'd1;
                    state_next = obcs_pkg::COS_TRY;
                end
            end
            default:
            begin
                state_next = obcs_pkg::COS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= obcs_pkg::COS_IDLE;
            cnt_reg   <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg   <= r_next;
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
        p_reg   <= p_next;
        q_reg   <= q_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        t_reg   <= t_next;
    end

    assign done  = done_reg;
    assign ratio = r_reg;

endmodule
`default_nettype wire

>>> rtl/obcs_checker.sv
// Port-level checks for the order book cosine similarity block.
// Depends on obcs_pkg; bound to the top level at the end of this file.
`default_nettype none
module obcs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic [1:0]                        opcode,
    input wire logic                              result_valid,
    input wire logic [obcs_pkg::PCT_W-1:0]        similarity_percent,
    input wire logic                              zero_length_error
);
    // A result strobe lasts a single cycle.
    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && zero_length_error) |-> (similarity_percent == '0))
        else $error("zero length result carries a nonzero percentage");

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !zero_length_error) |->
        ((similarity_percent >= obcs_pkg::HALF_SCALE) &&
         (similarity_percent <= obcs_pkg::FULL_SCALE)))
        else $error("similarity percentage out of range");

    // Items other than server items never raise busy.
    a_short_ops: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode != obcs_pkg::OP_SERVER)) |=> !busy)
        else $error("clear or append item raised busy");

    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without an item");

endmodule

bind order_book_cosine_similarity obcs_checker u_obcs_checker (.*);
`default_nettype wire
